/* rtl/olph_pkg.sv */
// package for the ordered linear-probe hash table
// request and response item types, slot marks, status and mode codes
// no dependencies
package olph_pkg;

    localparam int SlotsDefault = 1024;
    localparam int CntW         = 11;
    localparam int KeyW         = 32;
    localparam int ValW         = 32;

    localparam logic [CntW-1:0] CntMax        = 11'd2047;
    localparam logic [CntW-1:0] TableSizeRst  = 11'd1024;
    localparam logic [CntW-1:0] WindowRst     = 11'd256;

    // slot marks
    localparam logic [1:0] MarkEmpty = 2'd0;
    localparam logic [1:0] MarkFull  = 2'd1;
    localparam logic [1:0] MarkTomb  = 2'd2;

    // request modes
    localparam logic [1:0] ModeInsert = 2'd0;
    localparam logic [1:0] ModeQuery  = 2'd1;
    localparam logic [1:0] ModeRemove = 2'd2;

    // response status
    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StRebuild  = 3'd1;
    localparam logic [2:0] StDup      = 3'd2;
    localparam logic [2:0] StFull     = 3'd3;
    localparam logic [2:0] StNotFound = 3'd4;

    // configuration register indexes
    localparam logic CfgTableSize = 1'b0;
    localparam logic CfgWindow    = 1'b1;

    typedef struct packed {
        logic [1:0]      mode;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]      status;
        logic [ValW-1:0] found_value;
    } t_resp;

endpackage

/* rtl/olph_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module olph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ordered_linear_probe_hash_table.sv */
// ordered linear-probe hash table with tombstones and rebuild countdown
// depends on olph_pkg and olph_ram
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (olph_pkg::t_req)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (olph_pkg::t_resp)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item at a time; each is accepted, hashed and answered, and each probe step reads,
// waits, multiplies the hash and checks via the single read port and shared hash
// multiplier. an insert rechecks and writes its slot; if that slot is taken it first
// searches slot by slot for the cluster end and shifts the cluster one slot right.
// a query hit reads its value, a remove hit marks a tombstone, a full-table insert skips the probe.
// after reset the slot marks are cleared slot by slot with o_in_ready low;
// configuration writes are taken only while idle with no input item offered.
// a waiting result is held in the output register until taken, stalling the next one.
module ordered_linear_probe_hash_table #(
    parameter int SLOTS = olph_pkg::SlotsDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  olph_pkg::t_req                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output olph_pkg::t_resp                     o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [olph_pkg::CntW-1:0]           i_cfg_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = olph_pkg::CntW;
    localparam int XW = (AW > CW) ? AW : CW;
    localparam int PW = olph_pkg::KeyW + CW;
    localparam logic [XW:0]   SlotsX = (XW+1)'(SLOTS);
    localparam logic [AW-1:0] LastA  = AW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HASH, S_P_RD, S_P_WAIT, S_P_MUL, S_P_CHK,
        S_I_RD, S_I_WAIT, S_I_CHK, S_E_STEP, S_E_WAIT, S_E_CHK,
        S_SH_CHK, S_SH_WAIT, S_SH_WR, S_I_WR, S_Q_WAIT, S_Q_DONE,
        S_R_WR, S_RESP
    } t_state;

    t_state r_state;

    logic [1:0]                   r_mode;
    logic [olph_pkg::KeyW-1:0]    r_key;
    logic [olph_pkg::ValW-1:0]    r_val;
    logic [XW-1:0]                r_n, r_h, r_head, r_s, r_end, r_steps, r_i, r_p;
    logic [XW-1:0]                r_wrap_head;
    logic                         r_wrapped;
    logic [1:0]                   r_m;
    logic                         r_kmatch;
    logic [CW-1:0]                r_hk;
    logic [CW-1:0]                r_key_cnt, r_tomb_cnt, r_wc, r_ts;
    logic [AW-1:0]                r_ra, r_clr;
    logic [2:0]                   r_pst;
    logic [olph_pkg::ValW-1:0]    r_pfv;
    logic                         r_ov;
    olph_pkg::t_resp              r_out;

    // ram ports
    logic                         w_we_kv, w_we_m;
    logic [AW-1:0]                w_wa;
    logic [olph_pkg::KeyW-1:0]    w_wkey, w_rkey;
    logic [olph_pkg::ValW-1:0]    w_wval, w_rval;
    logic [1:0]                   w_wmark, w_rmark;

    // shared hash multiplier and helpers
    logic [olph_pkg::KeyW-1:0]    w_mul_a;
    logic [PW-1:0]                w_prod;
    logic [CW-1:0]                w_hash;
    logic [XW-1:0]                w_n_in, w_s_next, w_e_next, w_p, w_head_in, w_head_adv;
    logic [CW-1:0]                w_wc_dn;
    logic [2:0]                   w_st_dn;

    assign w_mul_a = (r_state == S_HASH) ? r_key : w_rkey;
    assign w_prod  = PW'(w_mul_a) * PW'(r_n[CW-1:0]);
    assign w_hash  = w_prod[PW-1:olph_pkg::KeyW];

    // slots in use from the table size register
    always_comb begin
        if (r_ts == '0) begin
            w_n_in = XW'(1);
        end else if ((XW+1)'(r_ts) > SlotsX) begin
            w_n_in = XW'(SLOTS);
        end else begin
            w_n_in = XW'(r_ts);
        end
    end

    assign w_head_in  = (r_wrap_head < r_n) ? r_wrap_head : '0;
    assign w_s_next   = ((r_s + XW'(1)) >= r_n) ? '0 : r_s + XW'(1);
    assign w_e_next   = ((r_end + XW'(1)) >= r_n) ? '0 : r_end + XW'(1);
    assign w_p        = (r_i == '0) ? r_n - XW'(1) : r_i - XW'(1);
    assign w_head_adv = ((r_head + XW'(1)) >= r_n) ? '0 : r_head + XW'(1);
    assign w_wc_dn    = (r_wc != '0) ? r_wc - CW'(1) : '0;
    assign w_st_dn    = (w_wc_dn == '0) ? olph_pkg::StRebuild : olph_pkg::StOk;

    // write side of the rams
    always_comb begin
        w_we_kv = 1'b0;
        w_we_m  = 1'b0;
        w_wa    = r_s[AW-1:0];
        w_wkey  = r_key;
        w_wval  = r_val;
        w_wmark = olph_pkg::MarkFull;
        unique case (r_state)
            S_CLEAR: begin
                w_we_m  = 1'b1;
                w_wa    = r_clr;
                w_wmark = olph_pkg::MarkEmpty;
            end
            S_SH_WR: begin
                w_we_kv = 1'b1;
                w_we_m  = 1'b1;
                w_wa    = r_i[AW-1:0];
                w_wkey  = w_rkey;
                w_wval  = w_rval;
                w_wmark = w_rmark;
            end
            S_I_WR: begin
                w_we_kv = 1'b1;
                w_we_m  = 1'b1;
            end
            S_R_WR: begin
                w_we_m  = 1'b1;
                w_wmark = olph_pkg::MarkTomb;
            end
            default: begin
            end
        endcase
    end

    olph_ram #(.WIDTH(olph_pkg::KeyW), .DEPTH(SLOTS)) u_key_ram (
        .i_clk(i_clk), .i_we(w_we_kv), .i_waddr(w_wa), .i_wdata(w_wkey),
        .i_raddr(r_ra), .o_rdata(w_rkey)
    );

    olph_ram #(.WIDTH(olph_pkg::ValW), .DEPTH(SLOTS)) u_val_ram (
        .i_clk(i_clk), .i_we(w_we_kv), .i_waddr(w_wa), .i_wdata(w_wval),
        .i_raddr(r_ra), .o_rdata(w_rval)
    );

    olph_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark_ram (
        .i_clk(i_clk), .i_we(w_we_m), .i_waddr(w_wa), .i_wdata(w_wmark),
        .i_raddr(r_ra), .o_rdata(w_rmark)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ov        <= 1'b0;
            r_wrap_head <= '0;
            r_key_cnt   <= '0;
            r_tomb_cnt  <= '0;
            r_ts        <= olph_pkg::TableSizeRst;
            r_wc        <= olph_pkg::WindowRst;
        end else begin
            if (r_ov && i_out_ready && r_state != S_RESP) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LastA) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode    <= i_in_data.mode;
                        r_key     <= i_in_data.key;
                        r_val     <= i_in_data.value;
                        r_n       <= w_n_in;
                        r_wrapped <= 1'b0;
                        r_pfv     <= '0;
                        if (i_in_data.mode != olph_pkg::ModeInsert &&
                            i_in_data.mode != olph_pkg::ModeQuery &&
                            i_in_data.mode != olph_pkg::ModeRemove) begin
                            r_pst   <= olph_pkg::StNotFound;
                            r_state <= S_RESP;
                        end else if (i_in_data.mode == olph_pkg::ModeInsert &&
                                     XW'(r_key_cnt) >= w_n_in) begin
                            r_pst   <= olph_pkg::StFull;
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    r_h     <= XW'(w_hash);
                    r_head  <= w_head_in;
                    r_s     <= (XW'(w_hash) > w_head_in) ? XW'(w_hash) : w_head_in;
                    r_state <= S_P_RD;
                end
                S_P_RD: begin
                    r_ra    <= r_s[AW-1:0];
                    r_state <= S_P_WAIT;
                end
                S_P_WAIT: begin
                    r_state <= S_P_MUL;
                end
                S_P_MUL: begin
                    r_m      <= w_rmark;
                    r_kmatch <= (w_rkey == r_key);
                    r_hk     <= w_hash;
                    r_state  <= S_P_CHK;
                end
                S_P_CHK: begin
                    // key match, end of run, or step on
                    if (r_m == olph_pkg::MarkFull && r_kmatch) begin
                        priority case (r_mode)
                            olph_pkg::ModeInsert: begin
                                r_pst   <= olph_pkg::StDup;
                                r_state <= S_RESP;
                            end
                            olph_pkg::ModeQuery: begin
                                r_ra    <= r_s[AW-1:0];
                                r_state <= S_Q_WAIT;
                            end
                            default: begin
                                r_state <= S_R_WR;
                            end
                        endcase
                    end else if (r_m == olph_pkg::MarkEmpty ||
                                 (r_m == olph_pkg::MarkFull && XW'(r_hk) > r_h) ||
                                 w_s_next == r_head) begin
                        if (!(r_m == olph_pkg::MarkEmpty ||
                              (r_m == olph_pkg::MarkFull && XW'(r_hk) > r_h))) begin
                            r_s <= w_s_next;
                            if (w_s_next == '0) begin
                                r_wrapped <= 1'b1;
                            end
                        end
                        if (r_mode == olph_pkg::ModeInsert) begin
                            r_state <= S_I_RD;
                        end else begin
                            r_pst   <= olph_pkg::StNotFound;
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_s <= w_s_next;
                        if (w_s_next == '0) begin
                            r_wrapped <= 1'b1;
                        end
                        r_state <= S_P_RD;
                    end
                end
                S_I_RD: begin
                    r_ra    <= r_s[AW-1:0];
                    r_state <= S_I_WAIT;
                end
                S_I_WAIT: begin
                    r_state <= S_I_CHK;
                end
                S_I_CHK: begin
                    if (w_rmark == olph_pkg::MarkEmpty) begin
                        if (r_wrapped && r_s == r_head) begin
                            r_wrap_head <= w_head_adv;
                        end
                        r_state <= S_I_WR;
                    end else begin
                        r_end   <= r_s;
                        r_steps <= '0;
                        r_state <= S_E_STEP;
                    end
                end
                // search for the slot that ends the cluster
                S_E_STEP: begin
                    r_end   <= w_e_next;
                    r_ra    <= w_e_next[AW-1:0];
                    r_steps <= r_steps + XW'(1);
                    r_state <= S_E_WAIT;
                end
                S_E_WAIT: begin
                    r_state <= S_E_CHK;
                end
                S_E_CHK: begin
                    if (w_rmark == olph_pkg::MarkFull && r_steps < r_n) begin
                        r_state <= S_E_STEP;
                    end else if (w_rmark == olph_pkg::MarkFull) begin
                        r_pst   <= olph_pkg::StFull;
                        r_state <= S_RESP;
                    end else begin
                        if (w_rmark == olph_pkg::MarkTomb && r_tomb_cnt != '0) begin
                            r_tomb_cnt <= r_tomb_cnt - CW'(1);
                        end
                        r_i     <= r_end;
                        r_state <= S_SH_CHK;
                    end
                end
                // shift the cluster one slot right
                S_SH_CHK: begin
                    if (r_i == r_s) begin
                        if ((r_end < r_s || r_wrapped) && r_end >= r_head) begin
                            r_wrap_head <= w_head_adv;
                        end
                        r_state <= S_I_WR;
                    end else begin
                        r_p     <= w_p;
                        r_ra    <= w_p[AW-1:0];
                        r_state <= S_SH_WAIT;
                    end
                end
                S_SH_WAIT: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_i     <= r_p;
                    r_state <= S_SH_CHK;
                end
                S_I_WR: begin
                    if (r_key_cnt != olph_pkg::CntMax) begin
                        r_key_cnt <= r_key_cnt + CW'(1);
                    end
                    r_wc    <= w_wc_dn;
                    r_pst   <= w_st_dn;
                    r_state <= S_RESP;
                end
                S_Q_WAIT: begin
                    r_state <= S_Q_DONE;
                end
                S_Q_DONE: begin
                    r_pfv   <= w_rval;
                    r_pst   <= olph_pkg::StOk;
                    r_state <= S_RESP;
                end
                S_R_WR: begin
                    if (r_tomb_cnt != olph_pkg::CntMax) begin
                        r_tomb_cnt <= r_tomb_cnt + CW'(1);
                    end
                    if (r_key_cnt != '0) begin
                        r_key_cnt <= r_key_cnt - CW'(1);
                    end
                    r_wc    <= w_wc_dn;
                    r_pst   <= w_st_dn;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov              <= 1'b1;
                        r_out.status      <= r_pst;
                        r_out.found_value <= r_pfv;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // configuration writes, only while idle
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    olph_pkg::CfgTableSize: r_ts <= i_cfg_data;
                    olph_pkg::CfgWindow:    r_wc <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;

endmodule
